// ----- hdl/box_blur_5x5_clipped_top_assert.svh -----
// Assertion macros used by the box blur controller.
`ifndef BOX_BLUR_5X5_CLIPPED_TOP_ASSERT_SVH
`define BOX_BLUR_5X5_CLIPPED_TOP_ASSERT_SVH

// cond in this cycle implies prop in the same cycle
`define BB5_ASSERT_IMPLY(name, clk, rst, cond, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("bb5 assertion failed");

// cond in this cycle implies prop in the next cycle
`define BB5_ASSERT_NEXT(name, clk, rst, cond, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("bb5 assertion failed");

`endif

// ----- hdl/bb5_pkg.sv -----
package bb5_pkg;

   localparam int MAX_WIDTH_DEF    = 4096;
   localparam int MAX_CHANNELS_DEF = 4;
   localparam int RADIUS_DEF       = 2;
   localparam int HEIGHT_LIMIT     = 4096;
   localparam int HEIGHT_W         = $clog2(HEIGHT_LIMIT + 1);
   localparam int CFG_W            = 13;
   localparam int LANES            = 4;
   localparam int RECIP_SHIFT      = 18;
   localparam int RECIP_W          = 19;

   typedef enum logic [1:0] {
      REG_WIDTH    = 2'd0,
      REG_HEIGHT   = 2'd1,
      REG_CHANNELS = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic req_ok;   // may take a request this cycle
      logic cfg_ok;   // may take a register write this cycle
      logic eval;     // store pixel, advance input position
      logic step;     // issue one window tap read
      logic mult;     // scale sums by reciprocal of count
      logic load;     // move result into output register
   } cmd_type;

   typedef struct packed {
      logic produce;
      logic tap_last;
      logic out_busy;
   } status_type;

   // ceil(2^18 / c): exact truncating quotient for sums below 2^13
   function automatic logic [RECIP_W-1:0] recip(input logic [4:0] c);
      logic [RECIP_W-1:0] r;
      unique case (c)
         5'd1:    r = 19'd262144;
         5'd2:    r = 19'd131072;
         5'd3:    r = 19'd87382;
         5'd4:    r = 19'd65536;
         5'd5:    r = 19'd52429;
         5'd6:    r = 19'd43691;
         5'd7:    r = 19'd37450;
         5'd8:    r = 19'd32768;
         5'd9:    r = 19'd29128;
         5'd10:   r = 19'd26215;
         5'd11:   r = 19'd23832;
         5'd12:   r = 19'd21846;
         5'd13:   r = 19'd20165;
         5'd14:   r = 19'd18725;
         5'd15:   r = 19'd17477;
         5'd16:   r = 19'd16384;
         5'd17:   r = 19'd15421;
         5'd18:   r = 19'd14564;
         5'd19:   r = 19'd13798;
         5'd20:   r = 19'd13108;
         5'd21:   r = 19'd12484;
         5'd22:   r = 19'd11916;
         5'd23:   r = 19'd11398;
         5'd24:   r = 19'd10923;
         5'd25:   r = 19'd10486;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ----- hdl/box_blur_5x5_clipped_top.sv -----
// Clipped 5x5 box mean over a raster pixel stream.
// req_ channel: one pixel (four 8-bit samples) or a flush request per accept,
// in raster order. rsp_ channel: per-channel means of the neighborhood that
// lies inside the frame, plus an end-of-frame mark on the last pixel.
// csr_ channel: index 0 frame width, 1 frame height, 2 channel count; a write
// to one of these restarts the frame. Write only while no request is in progress.
// Output pixel n comes out for the request at stream position n + 2*width + 2;
// after the last pixel, send flush requests to drain the tail.
// A request that yields no result is evaluated and the block returns to idle. For
// one that yields a result, the 25 window taps are read one per cycle from the
// single read port of the row store; the last read then drains, the reciprocal
// multiply runs and the output load follows.
// The output register holds a finished result while the receiver stalls; the
// next request is taken meanwhile, and a new result waits until it drains.
// Reset clears positions and sets width 1, height 1, three channels.
module box_blur_5x5_clipped_top #(
   parameter int MAX_WIDTH    = bb5_pkg::MAX_WIDTH_DEF,
   parameter int MAX_CHANNELS = bb5_pkg::MAX_CHANNELS_DEF,
   parameter int RADIUS       = bb5_pkg::RADIUS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_is_flush,
   input  logic [7:0]                req_sample_a,
   input  logic [7:0]                req_sample_b,
   input  logic [7:0]                req_sample_c,
   input  logic [7:0]                req_sample_d,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_mean_a,
   output logic [7:0]                rsp_mean_b,
   output logic [7:0]                rsp_mean_c,
   output logic [7:0]                rsp_mean_d,
   output logic                      rsp_end_of_frame,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [bb5_pkg::CFG_W-1:0] csr_data
);

   bb5_pkg::cmd_type    cmd;
   bb5_pkg::status_type status;

   bb5_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .csr_valid (csr_valid),
      .status_i  (status),
      .cmd_o     (cmd)
   );

   bb5_dpath #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_CHANNELS (MAX_CHANNELS),
      .RADIUS       (RADIUS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd_i            (cmd),
      .status_o         (status),
      .req_valid        (req_valid),
      .req_is_flush     (req_is_flush),
      .req_sample_a     (req_sample_a),
      .req_sample_b     (req_sample_b),
      .req_sample_c     (req_sample_c),
      .req_sample_d     (req_sample_d),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_mean_a       (rsp_mean_a),
      .rsp_mean_b       (rsp_mean_b),
      .rsp_mean_c       (rsp_mean_c),
      .rsp_mean_d       (rsp_mean_d),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

   assign req_ready = cmd.req_ok;
   assign csr_ready = cmd.cfg_ok;

endmodule

// ----- hdl/bb5_ctrl.sv -----
`include "box_blur_5x5_clipped_top_assert.svh"

module bb5_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 csr_valid,
   input  bb5_pkg::status_type  status_i,
   output bb5_pkg::cmd_type     cmd_o
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_GATHER,
      ST_DRAIN,
      ST_MULT,
      ST_OUT
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && !csr_valid) state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               state_ff <= status_i.produce ? ST_GATHER : ST_IDLE;
            end
            ST_GATHER: begin
               if (status_i.tap_last) state_ff <= ST_DRAIN;
            end
            ST_DRAIN: state_ff <= ST_MULT;
            ST_MULT:  state_ff <= ST_OUT;
            ST_OUT: begin
               if (!status_i.out_busy) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd_o        = '0;
      cmd_o.req_ok = (state_ff == ST_IDLE) && !csr_valid;
      cmd_o.cfg_ok = (state_ff == ST_IDLE);
      cmd_o.eval   = (state_ff == ST_EVAL);
      cmd_o.step   = (state_ff == ST_GATHER);
      cmd_o.mult   = (state_ff == ST_MULT);
      cmd_o.load   = (state_ff == ST_OUT) && !status_i.out_busy;
   end

   `BB5_ASSERT_IMPLY(a_load_slot_free, clock, reset, cmd_o.load, !status_i.out_busy)
   `BB5_ASSERT_NEXT(a_take_then_eval, clock, reset, cmd_o.req_ok && req_valid, state_ff == ST_EVAL)
   `BB5_ASSERT_NEXT(a_last_tap_drains, clock, reset, cmd_o.step && status_i.tap_last, state_ff == ST_DRAIN)

endmodule

// ----- hdl/bb5_dpath.sv -----
module bb5_dpath #(
   parameter int MAX_WIDTH    = bb5_pkg::MAX_WIDTH_DEF,
   parameter int MAX_CHANNELS = bb5_pkg::MAX_CHANNELS_DEF,
   parameter int RADIUS       = bb5_pkg::RADIUS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bb5_pkg::cmd_type          cmd_i,
   output bb5_pkg::status_type       status_o,
   input  logic                      req_valid,
   input  logic                      req_is_flush,
   input  logic [7:0]                req_sample_a,
   input  logic [7:0]                req_sample_b,
   input  logic [7:0]                req_sample_c,
   input  logic [7:0]                req_sample_d,
   input  logic                      csr_valid,
   input  logic [1:0]                csr_index,
   input  logic [bb5_pkg::CFG_W-1:0] csr_data,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [7:0]                rsp_mean_a,
   output logic [7:0]                rsp_mean_b,
   output logic [7:0]                rsp_mean_c,
   output logic [7:0]                rsp_mean_d,
   output logic                      rsp_end_of_frame
);

   localparam int SPAN   = 2 * RADIUS + 1;
   localparam int TAPS   = SPAN * SPAN;
   localparam int DEPTH  = 2 * RADIUS * MAX_WIDTH + 2 * RADIUS + 1;
   localparam int AW     = $clog2(DEPTH);
   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int HW     = bb5_pkg::HEIGHT_W;
   localparam int TOT_W  = WW + HW;
   localparam int POS_W  = TOT_W + 1;
   localparam int LAG_W  = WW + 2;
   localparam int MW     = 8 * MAX_CHANNELS;
   localparam int CNT_W  = $clog2(TAPS + 1);
   localparam int SUM_W  = 8 + CNT_W;
   localparam int PROD_W = SUM_W + bb5_pkg::RECIP_W;
   localparam int TAP_CW = $clog2(TAPS);
   localparam int DX_W   = $clog2(SPAN);
   localparam int LANES  = bb5_pkg::LANES;

   // configuration
   logic [bb5_pkg::CFG_W-1:0] width_cfg_ff, height_cfg_ff;
   logic [2:0]                chan_cfg_ff;
   logic [WW-1:0]             eff_w, eff_w_ff;
   logic [HW-1:0]             eff_h, eff_h_ff;
   logic [TOT_W-1:0]          total_ff;
   logic [LAG_W-1:0]          lag_ff;
   logic [2:0]                used;

   // request hold
   logic          flush_ff;
   logic [MW-1:0] pix_ff;
   logic [31:0]   pix_all;

   // positions
   logic [POS_W-1:0] in_pos_ff;
   logic [AW-1:0]    wr_ptr_ff;
   logic [TOT_W-1:0] out_pos_ff;
   logic [AW-1:0]    out_ptr_ff;
   logic [WW-1:0]    ox_ff;
   logic [HW-1:0]    oy_ff;

   // window walk
   logic [AW-1:0]        tap_ptr_ff;
   logic signed [WW:0]   tx_ff;
   logic signed [HW:0]   ty_ff;
   logic [DX_W-1:0]      dx_ff;
   logic [TAP_CW-1:0]    tap_cnt_ff;
   logic [AW-1:0]        start_ptr;
   logic [AW:0]          start_sum;
   logic [AW+1:0]        row_a, row_b, row_c;
   logic [AW-1:0]        col_ptr;
   logic                 tap_in;

   // memory and accumulation
   logic [MW-1:0]    mem [DEPTH];
   logic [MW-1:0]    rd_data_ff;
   logic [31:0]      rd_all;
   logic             rd_vld_ff, tap_in_ff;
   logic [SUM_W-1:0] sum_ff [LANES];
   logic [CNT_W-1:0] cnt_ff;
   logic [PROD_W-1:0] prod_ff [LANES];

   // output register
   logic             rsp_valid_ff, eof_ff;
   logic [7:0]       mean_ff [LANES];

   logic take, cfg_wr, cfg_hit, in_frame, drop, produce, eof, clear;
   logic [bb5_pkg::RECIP_W-1:0] rcp;

   assign take    = req_valid && cmd_i.req_ok;
   assign cfg_wr  = csr_valid && cmd_i.cfg_ok;
   assign pix_all = {req_sample_d, req_sample_c, req_sample_b, req_sample_a};

   always_comb begin
      if (width_cfg_ff == '0) eff_w = WW'(1);
      else if (32'(width_cfg_ff) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
      else eff_w = WW'(width_cfg_ff);
      if (height_cfg_ff == '0) eff_h = HW'(1);
      else if (32'(height_cfg_ff) > bb5_pkg::HEIGHT_LIMIT) eff_h = HW'(bb5_pkg::HEIGHT_LIMIT);
      else eff_h = HW'(height_cfg_ff);
      used = (32'(chan_cfg_ff) > MAX_CHANNELS) ? 3'(MAX_CHANNELS) : chan_cfg_ff;
   end

   always_comb begin
      unique case (csr_index)
         bb5_pkg::REG_WIDTH, bb5_pkg::REG_HEIGHT, bb5_pkg::REG_CHANNELS: cfg_hit = 1'b1;
         default: cfg_hit = 1'b0;
      endcase
   end

   assign in_frame = in_pos_ff < POS_W'(total_ff);
   assign drop     = in_frame && flush_ff;
   assign produce  = !drop && (in_pos_ff >= POS_W'(lag_ff));
   assign eof      = (TOT_W + 1)'(out_pos_ff) + 1'b1 >= (TOT_W + 1)'(total_ff);
   assign clear    = (cfg_wr && cfg_hit) || (cmd_i.load && eof);

   assign status_o.produce  = produce;
   assign status_o.tap_last = tap_cnt_ff == TAP_CW'(TAPS - 1);
   assign status_o.out_busy = rsp_valid_ff && !rsp_ready;

   // first tap sits lag entries behind the output pixel in the ring
   always_comb begin
      if ((AW + 1)'(out_ptr_ff) >= (AW + 1)'(lag_ff))
         start_sum = (AW + 1)'(out_ptr_ff) - (AW + 1)'(lag_ff);
      else
         start_sum = (AW + 1)'(out_ptr_ff) + (AW + 1)'(DEPTH) - (AW + 1)'(lag_ff);
      start_ptr = AW'(start_sum);

      row_a = (AW + 2)'(tap_ptr_ff) + (AW + 2)'(eff_w_ff);
      if (row_a >= (AW + 2)'(2 * RADIUS)) row_b = row_a - (AW + 2)'(2 * RADIUS);
      else row_b = row_a + (AW + 2)'(DEPTH) - (AW + 2)'(2 * RADIUS);
      if (row_b >= (AW + 2)'(DEPTH)) row_c = row_b - (AW + 2)'(DEPTH);
      else row_c = row_b;

      col_ptr = (tap_ptr_ff == AW'(DEPTH - 1)) ? '0 : tap_ptr_ff + 1'b1;

      tap_in = !tx_ff[WW] && (tx_ff < $signed({1'b0, eff_w_ff}))
            && !ty_ff[HW] && (ty_ff < $signed({1'b0, eff_h_ff}));
   end

   assign rd_all = 32'(rd_data_ff);
   assign rcp    = bb5_pkg::recip(5'(cnt_ff));

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= bb5_pkg::CFG_W'(1);
         height_cfg_ff <= bb5_pkg::CFG_W'(1);
         chan_cfg_ff   <= 3'd3;
         in_pos_ff     <= '0;
         wr_ptr_ff     <= '0;
         out_pos_ff    <= '0;
         out_ptr_ff    <= '0;
         ox_ff         <= '0;
         oy_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_vld_ff     <= 1'b0;
         tap_cnt_ff    <= '0;
      end else begin
         rd_vld_ff <= cmd_i.step;
         if (cfg_wr) begin
            unique case (csr_index)
               bb5_pkg::REG_WIDTH:    width_cfg_ff  <= csr_data;
               bb5_pkg::REG_HEIGHT:   height_cfg_ff <= csr_data;
               bb5_pkg::REG_CHANNELS: chan_cfg_ff   <= csr_data[2:0];
               default: ;
            endcase
         end
         if (clear) begin
            in_pos_ff  <= '0;
            wr_ptr_ff  <= '0;
            out_pos_ff <= '0;
            out_ptr_ff <= '0;
            ox_ff      <= '0;
            oy_ff      <= '0;
         end else begin
            if (cmd_i.eval && !drop) begin
               in_pos_ff <= in_pos_ff + 1'b1;
               if (in_frame)
                  wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
            end
            if (cmd_i.load) begin
               out_pos_ff <= out_pos_ff + 1'b1;
               out_ptr_ff <= (out_ptr_ff == AW'(DEPTH - 1)) ? '0 : out_ptr_ff + 1'b1;
               if ((WW + 1)'(ox_ff) + 1'b1 >= (WW + 1)'(eff_w_ff)) begin
                  ox_ff <= '0;
                  oy_ff <= oy_ff + 1'b1;
               end else begin
                  ox_ff <= ox_ff + 1'b1;
               end
            end
         end
         if (cmd_i.eval) tap_cnt_ff <= '0;
         else if (cmd_i.step) tap_cnt_ff <= tap_cnt_ff + 1'b1;
         if (cmd_i.load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      eff_w_ff <= eff_w;
      eff_h_ff <= eff_h;
      total_ff <= TOT_W'(eff_w) * TOT_W'(eff_h);
      lag_ff   <= LAG_W'(RADIUS) * LAG_W'(eff_w) + LAG_W'(RADIUS);
      if (take) begin
         flush_ff <= req_is_flush;
         pix_ff   <= pix_all[MW-1:0];
      end
      if (cmd_i.eval) begin
         tap_ptr_ff <= start_ptr;
         tx_ff      <= $signed({1'b0, ox_ff}) - (WW + 1)'(RADIUS);
         ty_ff      <= $signed({1'b0, oy_ff}) - (HW + 1)'(RADIUS);
         dx_ff      <= '0;
         cnt_ff     <= '0;
         for (int k = 0; k < LANES; k++) sum_ff[k] <= '0;
      end else begin
         if (cmd_i.step) begin
            tap_in_ff <= tap_in;
            if (dx_ff == DX_W'(SPAN - 1)) begin
               dx_ff      <= '0;
               tap_ptr_ff <= AW'(row_c);
               tx_ff      <= $signed({1'b0, ox_ff}) - (WW + 1)'(RADIUS);
               ty_ff      <= ty_ff + 1'b1;
            end else begin
               dx_ff      <= dx_ff + 1'b1;
               tap_ptr_ff <= col_ptr;
               tx_ff      <= tx_ff + 1'b1;
            end
         end
         if (rd_vld_ff && tap_in_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            for (int k = 0; k < LANES; k++)
               sum_ff[k] <= sum_ff[k] + SUM_W'(rd_all[8*k +: 8]);
         end
      end
      if (cmd_i.mult) begin
         for (int k = 0; k < LANES; k++)
            prod_ff[k] <= PROD_W'(sum_ff[k]) * PROD_W'(rcp);
      end
      if (cmd_i.load) begin
         eof_ff <= eof;
         for (int k = 0; k < LANES; k++) begin
            if (k < 32'(used) && cnt_ff != '0)
               mean_ff[k] <= 8'(prod_ff[k] >> bb5_pkg::RECIP_SHIFT);
            else
               mean_ff[k] <= '0;
         end
      end
   end

   // row store: one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd_i.eval && in_frame && !flush_ff) mem[wr_ptr_ff] <= pix_ff;
      rd_data_ff <= mem[tap_ptr_ff];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean_a       = mean_ff[0];
   assign rsp_mean_b       = mean_ff[1];
   assign rsp_mean_c       = mean_ff[2];
   assign rsp_mean_d       = mean_ff[3];
   assign rsp_end_of_frame = eof_ff;

endmodule
